// ===== src/mft_pkg.sv =====
// Shared types and constants for the motor feedback turn tracker.
package mft_pkg;

	// Field widths fixed by the feedback frame format.
	localparam int IdW    = 11;
	localparam int WordW  = 16;
	localparam int HallW  = 8;
	localparam int CntW   = 6;
	localparam int TurnW  = 32;
	localparam int CurW   = 14;
	localparam int IdxOutW = 3;

	// Configuration port.
	localparam int CfgIdxW  = 4;
	localparam int CfgDataW = 11;
	localparam logic [CfgIdxW-1:0] RegCalFrames = 4'd0;
	localparam logic [CfgIdxW-1:0] RegFirstId   = 4'd1;
	localparam logic [CntW-1:0]    CalFramesRst = 6'd50;
	localparam logic [IdW-1:0]     FirstIdRst   = 11'd513;

	// Tracking constants.
	localparam logic [CntW-1:0]   CntMax     = 6'd63;
	localparam logic signed [16:0] HalfTurnPos = 17'sd4096;
	localparam logic signed [16:0] HalfTurnNeg = -17'sd4096;
	localparam int FullTurnShift = 13;
	localparam logic signed [9:0] DegScale = 10'sd360;
	localparam logic signed [41:0] DegBias = 42'sd8191;
	// n / 5 == (n * 52429) >> 18 for every n below 2^16.
	localparam logic [15:0] Div5Recip = 16'd52429;
	localparam int Div5Shift = 18;

	// One motor record as held in the state memory.
	typedef struct packed {
		logic [CntW-1:0]  frame_count;
		logic [WordW-1:0] stored_angle;
		logic [WordW-1:0] offset_value;
		logic [TurnW-1:0] turn_count;
	} slot_rec_t;

	// Result of the record update, passed to the scaling pipeline.
	typedef struct packed {
		logic               calibrating;
		logic [IdxOutW-1:0] motor_index;
		logic [WordW-1:0]   speed_word;
		logic [WordW-1:0]   current_word;
		logic [HallW-1:0]   hall_byte;
		logic [WordW-1:0]   angle_now;
		logic [TurnW-1:0]   turns;
		logic [TurnW-1:0]   total_counts;
	} track_res_t;

endpackage

// ===== src/mft_intf.sv =====
// Channel interfaces for feedback frames, results and configuration writes.
interface mft_frame_if import mft_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IdW-1:0]   frame_id;
	logic [WordW-1:0] angle_word;
	logic [WordW-1:0] speed_word;
	logic [WordW-1:0] current_word;
	logic [HallW-1:0] hall_byte;

	modport source (output valid, frame_id, angle_word, speed_word, current_word, hall_byte,
		input ready);
	modport sink (input valid, frame_id, angle_word, speed_word, current_word, hall_byte,
		output ready);
endinterface

interface mft_result_if import mft_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [IdxOutW-1:0]       motor_index;
	logic                     calibrating;
	logic signed [WordW-1:0]  speed_value;
	logic signed [CurW-1:0]   current_value;
	logic [HallW-1:0]         hall_value;
	logic [WordW-1:0]         angle_now;
	logic signed [TurnW-1:0]  turns;
	logic signed [TurnW-1:0]  total_counts;
	logic signed [TurnW-1:0]  total_degrees;

	modport source (output valid, motor_index, calibrating, speed_value, current_value,
		hall_value, angle_now, turns, total_counts, total_degrees, input ready);
	modport sink (input valid, motor_index, calibrating, speed_value, current_value,
		hall_value, angle_now, turns, total_counts, total_degrees, output ready);
endinterface

interface mft_cfg_if import mft_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CfgIdxW-1:0]  reg_index;
	logic [CfgDataW-1:0] wr_data;

	modport source (output valid, reg_index, wr_data, input ready);
	modport sink (input valid, reg_index, wr_data, output ready);
endinterface

// ===== src/mft_state_mem.sv =====
// Per-motor record memory with registered read and reset valid bits.
module mft_state_mem import mft_pkg::*; #(
	parameter int Depth = 8,
	parameter int SlotW = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [SlotW-1:0] rd_addr,
	output slot_rec_t        rd_data,
	input  logic             wr_en,
	input  logic [SlotW-1:0] wr_addr,
	input  slot_rec_t        wr_data
);

	slot_rec_t        mem [Depth];
	slot_rec_t        rd_q;
	logic             rd_vld_q;
	logic [Depth-1:0] vld_q;

	// Record storage; written and read in the same clocked block.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Valid bits stand in for clearing the records at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// A record never written reads as zero.
	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

// ===== src/mft_scale.sv =====
// Scaling pipeline: degree product, current division and the result register.
module mft_scale import mft_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       up_valid,
	output logic       up_ready,
	input  track_res_t up_data,
	mft_result_if.source result
);

	logic       v2_q, v3_q, v4_q;
	logic       en2, en3, en4;
	track_res_t res_s2, res_s3;

	logic signed [41:0] deg_prod_c, deg_prod_s3, deg_biased_c;
	logic               cur_neg_c, cur_neg_s3;
	logic [WordW-1:0]   cur_mag_c;
	logic [31:0]        cur_prod_c, cur_prod_s3;
	logic [CurW-1:0]    cur_quot_c, cur_res_c;
	logic [TurnW-1:0]   deg_c;

	// Each stage moves on when the next one is empty or moving.
	assign en4      = !v4_q || result.ready;
	assign en3      = !v3_q || en4;
	assign en2      = !v2_q || en3;
	assign up_ready = en2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			if (en2) v2_q <= up_valid;
			if (en3) v3_q <= v2_q;
			if (en4) v4_q <= v3_q;
		end
	end

	// Products: total counts times 360 and current magnitude times the reciprocal of five.
	assign deg_prod_c = $signed(res_s2.total_counts) * DegScale;
	assign cur_neg_c  = res_s2.current_word[WordW-1];
	assign cur_mag_c  = cur_neg_c ? WordW'(-res_s2.current_word) : res_s2.current_word;
	assign cur_prod_c = 32'(cur_mag_c) * 32'(Div5Recip);

	// Finish: round the degree quotient toward zero and give the current quotient the opposite of the input sign.
	assign deg_biased_c = deg_prod_s3 + (deg_prod_s3[41] ? DegBias : 42'sd0);
	assign deg_c        = TurnW'(deg_biased_c >>> FullTurnShift);
	assign cur_quot_c   = cur_prod_s3[Div5Shift +: CurW];
	assign cur_res_c    = cur_neg_s3 ? cur_quot_c : CurW'(-cur_quot_c);

	// Pipeline payload registers.
	always_ff @(posedge clk) begin
		if (en2 && up_valid) begin
			res_s2 <= up_data;
		end
		if (en3 && v2_q) begin
			res_s3      <= res_s2;
			deg_prod_s3 <= deg_prod_c;
			cur_neg_s3  <= cur_neg_c;
			cur_prod_s3 <= cur_prod_c;
		end
		if (en4 && v3_q) begin
			result.motor_index <= res_s3.motor_index;
			result.calibrating <= res_s3.calibrating;
			result.angle_now   <= res_s3.angle_now;
			result.turns       <= res_s3.turns;
			if (res_s3.calibrating) begin
				result.speed_value   <= '0;
				result.current_value <= '0;
				result.hall_value    <= '0;
				result.total_counts  <= '0;
				result.total_degrees <= '0;
			end else begin
				result.speed_value   <= res_s3.speed_word;
				result.current_value <= cur_res_c;
				result.hall_value    <= res_s3.hall_byte;
				result.total_counts  <= res_s3.total_counts;
				result.total_degrees <= deg_c;
			end
		end
	end

	assign result.valid = v4_q;

endmodule

// ===== src/motor_feedback_turn_tracker.sv =====
// Top level of the motor feedback turn tracker.
// A frame is accepted in every cycle in which the result pipeline can move, so the
// sustained rate is one frame per clock; a frame whose id falls inside the motor window
// offers its result after the update stage and the scaling pipeline registers, and other
// frames are dropped. The per-motor record memory is read when a frame is accepted and
// written back as that frame leaves the update stage, with a bypass register when the
// next frame is for the same motor. Records start at zero after reset through per-entry
// valid bits, so no clearing pass is needed. Configuration writes are taken in any cycle.
module motor_feedback_turn_tracker import mft_pkg::*; #(
	parameter int MOTOR_SLOTS = 8
) (
	input  logic clk,
	input  logic arst_n,
	mft_cfg_if.sink      cfg,
	mft_frame_if.sink    frame,
	mft_result_if.source result
);

	localparam int SlotW = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;

	logic [CntW-1:0] cal_frames_q;
	logic [IdW-1:0]  first_id_q;

	logic           accept, hit, en2, v1_q, wr_en, fwd_s1;
	logic [IdW:0]   id_diff;
	logic [SlotW-1:0] slot_in, slot_s1;
	logic [IdxOutW-1:0] mi_s1;
	logic [WordW-1:0] ang_s1, spd_s1, cur_s1;
	logic [HallW-1:0] hall_s1;
	slot_rec_t      rd_rec, cur_rec, new_rec, fwd_rec_s1;
	track_res_t     res_c;

	logic                cal_c, inc_c, dec_c;
	logic signed [16:0]  jump_c;
	logic [TurnW-1:0]    turn_new_c;

	// Configuration registers; writes to unknown indexes are ignored.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_frames_q <= CalFramesRst;
			first_id_q   <= FirstIdRst;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				RegCalFrames: cal_frames_q <= cfg.wr_data[CntW-1:0];
				RegFirstId:   first_id_q   <= cfg.wr_data;
				default:      ;
			endcase
		end
	end

	// Slot selection: the id must lie in the window that starts at the first feedback id.
	assign id_diff = {1'b0, frame.frame_id} - {1'b0, first_id_q};
	assign hit     = !id_diff[IdW] && (id_diff[IdW-1:0] < IdW'(MOTOR_SLOTS));
	assign slot_in = id_diff[SlotW-1:0];

	// The update stage moves when empty or when the scaling pipeline takes its request.
	assign frame.ready = !v1_q || en2;
	assign accept      = frame.valid && frame.ready;
	assign wr_en       = v1_q && en2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (frame.ready) begin
			v1_q <= accept && hit;
		end
	end

	// Update stage payload, with bypass of a record being written in the same cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			slot_s1    <= slot_in;
			mi_s1      <= id_diff[IdxOutW-1:0];
			ang_s1     <= frame.angle_word;
			spd_s1     <= frame.speed_word;
			cur_s1     <= frame.current_word;
			hall_s1    <= frame.hall_byte;
			fwd_s1     <= wr_en && (slot_s1 == slot_in);
			fwd_rec_s1 <= new_rec;
		end
	end

	mft_state_mem #(
		.Depth (MOTOR_SLOTS),
		.SlotW (SlotW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && hit),
		.rd_addr (slot_in),
		.rd_data (rd_rec),
		.wr_en   (wr_en),
		.wr_addr (slot_s1),
		.wr_data (new_rec)
	);

	assign cur_rec = fwd_s1 ? fwd_rec_s1 : rd_rec;

	// Record update: calibration, saturating frame count and turn detection.
	assign cal_c      = cur_rec.frame_count <= cal_frames_q;
	assign jump_c     = $signed({1'b0, ang_s1}) - $signed({1'b0, cur_rec.stored_angle});
	assign dec_c      = !cal_c && (jump_c > HalfTurnPos);
	assign inc_c      = !cal_c && (jump_c < HalfTurnNeg);
	assign turn_new_c = dec_c ? cur_rec.turn_count - 32'd1 :
		inc_c ? cur_rec.turn_count + 32'd1 : cur_rec.turn_count;

	always_comb begin
		new_rec.frame_count  = (cur_rec.frame_count == CntMax) ? CntMax :
			cur_rec.frame_count + 6'd1;
		new_rec.stored_angle = ang_s1;
		new_rec.offset_value = cal_c ? ang_s1 : cur_rec.offset_value;
		new_rec.turn_count   = turn_new_c;
	end

	// Request towards the scaling pipeline.
	always_comb begin
		res_c.calibrating  = cal_c;
		res_c.motor_index  = mi_s1;
		res_c.speed_word   = spd_s1;
		res_c.current_word = cur_s1;
		res_c.hall_byte    = hall_s1;
		res_c.angle_now    = ang_s1;
		res_c.turns        = turn_new_c;
		res_c.total_counts = {turn_new_c[TurnW-FullTurnShift-1:0], FullTurnShift'(0)}
			+ TurnW'(ang_s1) - TurnW'(cur_rec.offset_value);
	end

	mft_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (v1_q),
		.up_ready (en2),
		.up_data  (res_c),
		.result   (result)
	);

endmodule

// ===== src/mft_checker.sv =====
// Port-level assertions for the motor feedback turn tracker, bound to the top level.
module mft_checker import mft_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic                    calibrating,
	input logic signed [TurnW-1:0] turns,
	input logic signed [TurnW-1:0] total_counts,
	input logic signed [TurnW-1:0] total_degrees
);

	// A stalled result stays offered.
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	// A stalled result keeps its turn count.
	a_turns_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(turns))
		else $error("result changed while stalled");

	// A calibration frame reports no position.
	a_cal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && calibrating |-> total_counts == 0 && total_degrees == 0)
		else $error("calibration result carries a position");

	// Degrees truncate toward zero, so a negative angle needs negative counts.
	a_deg_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !calibrating && total_degrees[TurnW-1] |-> total_counts[TurnW-1])
		else $error("degree sign does not follow total counts");

endmodule

bind motor_feedback_turn_tracker mft_checker u_mft_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.calibrating   (result.calibrating),
	.turns         (result.turns),
	.total_counts  (result.total_counts),
	.total_degrees (result.total_degrees)
);
